FILE: rtl/core/gjr_pkg.sv
// ----------------------------------------------------------------------------
// gjr_pkg
// Shared constants, codes and controller/datapath link types for the
// Gauss-Jordan reducer.
// ----------------------------------------------------------------------------
package gjr_pkg;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int RANK_W    = 4;

  // parameter defaults
  localparam int DEF_MAX_DIM   = 8;
  localparam int DEF_FRAC_BITS = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

  // write data select codes
  typedef logic [2:0] wr_sel_t;
  localparam wr_sel_t WR_IN    = 3'd0;
  localparam wr_sel_t WR_RDATA = 3'd1;
  localparam wr_sel_t WR_TMP   = 3'd2;
  localparam wr_sel_t WR_DIV   = 3'd3;
  localparam wr_sel_t WR_ELIM  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    ld_piv;
    logic    ld_f;
    logic    ld_tmp;
    logic    mul_en;
    logic    div_start;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_zero;
    logic div_done;
  } sts_t;

endpackage

FILE: rtl/core/gauss_jordan_rref.sv
// ----------------------------------------------------------------------------
// gauss_jordan_rref
// Gauss-Jordan reducer to reduced row echelon form, signed fixed point.
// ----------------------------------------------------------------------------
// Elements are loaded row-major, one per cycle while in_stall is low. The
// transfer of the last element starts the reduction, and in_stall stays high
// until the reduced matrix has been emitted. Reduction time is set by the
// matrix store, which has one read and one write port, and the bit-serial
// divider: each pivot row is normalized element by element through the
// divider (Q16.16 by default), each eliminated row is read and rewritten
// element by element, a row swap exchanges one column per pass, and emitting
// reads out one element per output transfer.
// ----------------------------------------------------------------------------
module gauss_jordan_rref import gjr_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] reduced_value,
  output logic                     is_last,
  output logic [RANK_W-1:0]        rank
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  cmd_t              cmd;
  sts_t              sts;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  // controller
  gjr_ctrl #(
    .MAX_DIM(MAX_DIM),
    .ADDR_W(ADDR_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_last(is_last),
    .rank(rank),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .sts(sts)
  );

  // datapath
  gjr_datapath #(
    .MAX_DIM(MAX_DIM),
    .FRAC_BITS(FRAC_BITS),
    .ADDR_W(ADDR_W)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .element_value(element_value),
    .sts(sts),
    .reduced_value(reduced_value)
  );

endmodule

FILE: rtl/core/gjr_div.sv
// ----------------------------------------------------------------------------
// gjr_div
// Iterative fixed-point divider: (a << FRAC_BITS) / p, truncated toward zero
// and saturated to 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gjr_div import gjr_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] dividend,
  input  logic signed [DATA_W-1:0] divisor,
  output logic                     done,
  output logic signed [DATA_W-1:0] quotient
);

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'({1'b1, {(DATA_W-1){1'b0}}});

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DATA_W-1:0] rem;
  logic [NUM_W-1:0]  quo;
  logic [DATA_W-1:0] den;
  logic              neg;

  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] p_mag;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   trial;

  // operand magnitudes
  assign a_mag = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
  assign p_mag = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);

  // restoring step
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign trial  = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= {a_mag, {FRAC_BITS{1'b0}}};
      rem <= '0;
      den <= p_mag;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  // sign and saturation
  always_comb begin
    if (!neg) begin
      quotient = (quo > POS_LIM) ? POS_LIM[DATA_W-1:0] : quo[DATA_W-1:0];
    end else begin
      quotient = (quo > NEG_LIM) ? NEG_LIM[DATA_W-1:0] : DATA_W'(-quo[DATA_W-1:0]);
    end
  end

endmodule

FILE: rtl/core/gjr_datapath.sv
// ----------------------------------------------------------------------------
// gjr_datapath
// Matrix store, pivot and factor registers, multiply-subtract unit, divider
// and output register.
// ----------------------------------------------------------------------------
module gjr_datapath import gjr_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int ADDR_W    = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic [ADDR_W-1:0]        rd_addr,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0] element_value,
  output sts_t                     sts,
  output logic signed [DATA_W-1:0] reduced_value
);

  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int PROD_W = 2 * DATA_W;

  logic signed [DATA_W-1:0] mem [CELLS];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] piv;
  logic signed [DATA_W-1:0] f;
  logic signed [DATA_W-1:0] tmp;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] diff;
  logic signed [DATA_W-1:0] elim;
  logic signed [DATA_W-1:0] quot;
  logic signed [DATA_W-1:0] wdata;
  logic                     div_done;

  // shared divider
  gjr_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .dividend(rdata),
    .divisor(piv),
    .done(div_done),
    .quotient(quot)
  );

  // e - floor(f * v / 2^FRAC_BITS), saturated
  assign diff = $signed({{DATA_W{rdata[DATA_W-1]}}, rdata}) - (prod >>> FRAC_BITS);
  always_comb begin
    if (diff[PROD_W-1:DATA_W-1] == '0 || diff[PROD_W-1:DATA_W-1] == '1) begin
      elim = diff[DATA_W-1:0];
    end else if (diff[PROD_W-1]) begin
      elim = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      elim = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // write data select
  always_comb begin
    case (cmd.wr_sel)
      WR_IN:    wdata = element_value;
      WR_RDATA: wdata = rdata;
      WR_TMP:   wdata = tmp;
      WR_DIV:   wdata = quot;
      WR_ELIM:  wdata = elim;
      default:  wdata = rdata;
    endcase
  end

  // matrix store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.ld_piv) begin
      piv <= rdata;
    end
    if (cmd.ld_f) begin
      f <= rdata;
    end
    if (cmd.ld_tmp) begin
      tmp <= rdata;
    end
    if (cmd.mul_en) begin
      prod <= PROD_W'(f) * PROD_W'(rdata);
    end
    if (cmd.out_load) begin
      reduced_value <= rdata;
    end
  end

  assign sts.rd_zero  = (rdata == '0);
  assign sts.div_done = div_done;

endmodule

FILE: rtl/core/gjr_ctrl.sv
// ----------------------------------------------------------------------------
// gjr_ctrl
// Sequencer for load, pivot search, row swap, normalize, eliminate and
// emit; holds the size registers, loop counters and rank.
// ----------------------------------------------------------------------------
module gjr_ctrl import gjr_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM,
  parameter int ADDR_W  = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 is_last,
  output logic [RANK_W-1:0]    rank,
  output cmd_t                 cmd,
  output logic [ADDR_W-1:0]    rd_addr,
  output logic [ADDR_W-1:0]    wr_addr,
  input  sts_t                 sts
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int TOT_W = 2 * DIM_W;
  localparam int ST_W  = 5;

  localparam logic [ST_W-1:0] S_IDLE   = 5'd0;
  localparam logic [ST_W-1:0] S_COL    = 5'd1;
  localparam logic [ST_W-1:0] S_PV_RD  = 5'd2;
  localparam logic [ST_W-1:0] S_PV_CHK = 5'd3;
  localparam logic [ST_W-1:0] S_SR_RD  = 5'd4;
  localparam logic [ST_W-1:0] S_SR_CHK = 5'd5;
  localparam logic [ST_W-1:0] S_SW_R1  = 5'd6;
  localparam logic [ST_W-1:0] S_SW_R2  = 5'd7;
  localparam logic [ST_W-1:0] S_SW_W1  = 5'd8;
  localparam logic [ST_W-1:0] S_SW_W2  = 5'd9;
  localparam logic [ST_W-1:0] S_NM_RD  = 5'd10;
  localparam logic [ST_W-1:0] S_NM_ST  = 5'd11;
  localparam logic [ST_W-1:0] S_NM_WT  = 5'd12;
  localparam logic [ST_W-1:0] S_EF_RD  = 5'd13;
  localparam logic [ST_W-1:0] S_EF_CHK = 5'd14;
  localparam logic [ST_W-1:0] S_EL_RV  = 5'd15;
  localparam logic [ST_W-1:0] S_EL_RE  = 5'd16;
  localparam logic [ST_W-1:0] S_EL_WR  = 5'd17;
  localparam logic [ST_W-1:0] S_NEXT   = 5'd18;
  localparam logic [ST_W-1:0] S_EM_RD  = 5'd19;
  localparam logic [ST_W-1:0] S_EM_LD  = 5'd20;
  localparam logic [ST_W-1:0] S_EM_WT  = 5'd21;

  logic [ST_W-1:0]   state, state_next;
  logic [CFG_W-1:0]  row_cfg, col_cfg;
  logic [DIM_W-1:0]  prow, prow_next;
  logic [DIM_W-1:0]  x, x_next;
  logic [DIM_W-1:0]  r, r_next;
  logic [DIM_W-1:0]  k, k_next;
  logic [ADDR_W-1:0] load_idx, load_idx_next;
  logic [ADDR_W-1:0] emit_idx, emit_idx_next;
  logic [DIM_W-1:0]  pivot_total, pivot_total_next;

  logic [DIM_W-1:0]  rows, cols;
  logic [TOT_W-1:0]  total;
  logic              emit_last;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if ((CFG_W+DIM_W)'(v) > (CFG_W+DIM_W)'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] row,
                                                  input logic [DIM_W-1:0] col,
                                                  input logic [DIM_W-1:0] ncols);
    logic [TOT_W-1:0] full;
    full = TOT_W'(row) * TOT_W'(ncols) + TOT_W'(col);
    return full[ADDR_W-1:0];
  endfunction

  // effective sizes
  assign rows      = clamp_dim(row_cfg);
  assign cols      = clamp_dim(col_cfg);
  assign total     = TOT_W'(rows) * TOT_W'(cols);
  assign emit_last = (TOT_W'(emit_idx) + TOT_W'(1) == total);

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cfg <= CFG_W'(DEF_MAX_DIM);
      col_cfg <= CFG_W'(DEF_MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROW_COUNT) begin
        row_cfg <= cfg_data;
      end
      if (cfg_index == REG_COL_COUNT) begin
        col_cfg <= cfg_data;
      end
    end
  end

  // handshake outputs
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EM_WT);
  assign is_last   = emit_last;
  assign rank      = RANK_W'(pivot_total);

  // sequencer
  always_comb begin
    state_next       = state;
    prow_next        = prow;
    x_next           = x;
    r_next           = r;
    k_next           = k;
    load_idx_next    = load_idx;
    emit_idx_next    = emit_idx;
    pivot_total_next = pivot_total;
    cmd              = '0;
    cmd.wr_sel       = WR_IN;
    rd_addr          = cell_addr(prow, x, cols);
    wr_addr          = cell_addr(prow, k, cols);

    case (state)
      S_IDLE: begin
        wr_addr = load_idx;
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          if (TOT_W'(load_idx) + TOT_W'(1) < total) begin
            load_idx_next = load_idx + 1'b1;
          end else begin
            load_idx_next = '0;
            prow_next     = '0;
            x_next        = '0;
            state_next    = S_COL;
          end
        end
      end
      S_COL: begin
        if (x >= cols || prow >= rows) begin
          pivot_total_next = prow;
          emit_idx_next    = '0;
          state_next       = S_EM_RD;
        end else begin
          state_next = S_PV_RD;
        end
      end
      S_PV_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_PV_CHK;
      end
      S_PV_CHK: begin
        if (!sts.rd_zero) begin
          cmd.ld_piv = 1'b1;
          k_next     = '0;
          state_next = S_NM_RD;
        end else if (prow + 1'b1 >= rows) begin
          x_next     = x + 1'b1;
          state_next = S_COL;
        end else begin
          r_next     = prow + 1'b1;
          state_next = S_SR_RD;
        end
      end
      // search below for a nonzero entry
      S_SR_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = cell_addr(r, x, cols);
        state_next = S_SR_CHK;
      end
      S_SR_CHK: begin
        if (!sts.rd_zero) begin
          cmd.ld_piv = 1'b1;
          k_next     = '0;
          state_next = S_SW_R1;
        end else if (r + 1'b1 >= rows) begin
          x_next     = x + 1'b1;
          state_next = S_COL;
        end else begin
          r_next     = r + 1'b1;
          state_next = S_SR_RD;
        end
      end
      // row swap, one column per pass
      S_SW_R1: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = cell_addr(r, k, cols);
        state_next = S_SW_R2;
      end
      S_SW_R2: begin
        cmd.ld_tmp = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_addr    = cell_addr(prow, k, cols);
        state_next = S_SW_W1;
      end
      S_SW_W1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_RDATA;
        wr_addr    = cell_addr(r, k, cols);
        state_next = S_SW_W2;
      end
      S_SW_W2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_TMP;
        if (k + 1'b1 >= cols) begin
          k_next     = '0;
          state_next = S_NM_RD;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_SW_R1;
        end
      end
      // divide pivot row by pivot
      S_NM_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = cell_addr(prow, k, cols);
        state_next = S_NM_ST;
      end
      S_NM_ST: begin
        cmd.div_start = 1'b1;
        state_next    = S_NM_WT;
      end
      S_NM_WT: begin
        if (sts.div_done) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_DIV;
          if (k + 1'b1 >= cols) begin
            r_next     = '0;
            state_next = S_EF_RD;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_NM_RD;
          end
        end
      end
      // fetch elimination factor of row r
      S_EF_RD: begin
        rd_addr = cell_addr(r, x, cols);
        if (r >= rows) begin
          state_next = S_NEXT;
        end else if (r == prow) begin
          r_next = r + 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_EF_CHK;
        end
      end
      S_EF_CHK: begin
        if (sts.rd_zero) begin
          r_next     = r + 1'b1;
          state_next = S_EF_RD;
        end else begin
          cmd.ld_f   = 1'b1;
          k_next     = '0;
          state_next = S_EL_RV;
        end
      end
      // row r minus factor times pivot row
      S_EL_RV: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = cell_addr(prow, k, cols);
        state_next = S_EL_RE;
      end
      S_EL_RE: begin
        cmd.mul_en = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_addr    = cell_addr(r, k, cols);
        state_next = S_EL_WR;
      end
      S_EL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_ELIM;
        wr_addr    = cell_addr(r, k, cols);
        if (k + 1'b1 >= cols) begin
          r_next     = r + 1'b1;
          state_next = S_EF_RD;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_EL_RV;
        end
      end
      S_NEXT: begin
        prow_next  = prow + 1'b1;
        x_next     = x + 1'b1;
        state_next = S_COL;
      end
      // emit reduced matrix
      S_EM_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = emit_idx;
        state_next = S_EM_LD;
      end
      S_EM_LD: begin
        cmd.out_load = 1'b1;
        state_next   = S_EM_WT;
      end
      S_EM_WT: begin
        if (!out_stall) begin
          if (emit_last) begin
            state_next = S_IDLE;
          end else begin
            emit_idx_next = emit_idx + 1'b1;
            state_next    = S_EM_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      prow        <= '0;
      x           <= '0;
      r           <= '0;
      k           <= '0;
      load_idx    <= '0;
      emit_idx    <= '0;
      pivot_total <= '0;
    end else begin
      state       <= state_next;
      prow        <= prow_next;
      x           <= x_next;
      r           <= r_next;
      k           <= k_next;
      load_idx    <= load_idx_next;
      emit_idx    <= emit_idx_next;
      pivot_total <= pivot_total_next;
    end
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gauss-Jordan reducer: a directed table of small
// matrices and size corner cases, then random matrices of random size. Every
// transferred element feeds a local fixed-point predictor whose reduced
// matrices are queued and compared against the output stream.
// ----------------------------------------------------------------------------
module tb import gjr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM   = DEF_MAX_DIM;
  localparam int FRAC  = DEF_FRAC_BITS;
  localparam int CELLS = DIM * DIM;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] element_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] reduced_value;
  logic                     is_last;
  logic [RANK_W-1:0]        rank;

  gauss_jordan_rref uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .element_value(element_value),
    .out_valid(out_valid), .out_stall(out_stall), .reduced_value(reduced_value),
    .is_last(is_last), .rank(rank)
  );

  always #10 clk = ~clk;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic [RANK_W-1:0]        rank;
  } reduced_elem_t;

  reduced_elem_t expected_elems[$];
  bit            failed = 1'b0;

  // predictor state
  logic signed [DATA_W-1:0] mat[CELLS];
  int unsigned              load_pos = 0;
  logic [CFG_W-1:0]         rows_reg = 4'd8;
  logic [CFG_W-1:0]         cols_reg = 4'd8;

  // receiver control
  int  hold_off = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;
  bit  stall_on = 1'b0;

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return 32'(v);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat(longint v);
    if (v > S32_MAX) return S32_MAX[DATA_W-1:0];
    if (v < S32_MIN) return S32_MIN[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  // in-place gauss-jordan on the predictor copy, returns pivot count
  function automatic int unsigned rref_pivots(int unsigned nr, int unsigned nc);
    int unsigned prow;
    logic signed [DATA_W-1:0] piv, f, t;
    longint num, prod;
    prow = 0;
    for (int x = 0; x < nc; x++) begin
      if (prow >= nr) break;
      piv = mat[prow*nc + x];
      if (piv == 0) begin
        for (int r = prow + 1; r < nr; r++) begin
          if (mat[r*nc + x] != 0) begin
            for (int k = 0; k < nc; k++) begin
              t = mat[r*nc + k];
              mat[r*nc + k] = mat[prow*nc + k];
              mat[prow*nc + k] = t;
            end
            break;
          end
        end
        piv = mat[prow*nc + x];
      end
      if (piv == 0) continue;
      for (int k = 0; k < nc; k++) begin
        num = longint'(mat[prow*nc + k]) <<< FRAC;
        mat[prow*nc + k] = sat(num / longint'(piv));
      end
      for (int r = 0; r < nr; r++) begin
        if (r == prow) continue;
        f = mat[r*nc + x];
        if (f == 0) continue;
        for (int k = 0; k < nc; k++) begin
          prod = longint'(f) * longint'(mat[prow*nc + k]);
          mat[r*nc + k] = sat(longint'(mat[r*nc + k]) - (prod >>> FRAC));
        end
      end
      prow++;
    end
    return prow;
  endfunction

  // element bookkeeping; typed expectation replaces prediction for 1x1 rows
  task automatic absorb_element(logic signed [DATA_W-1:0] v, bit has_exp,
                                logic signed [DATA_W-1:0] exp_val,
                                logic [RANK_W-1:0] exp_rank);
    int unsigned nr, nc, total, rk;
    reduced_elem_t e;
    nr = eff_dim(rows_reg);
    nc = eff_dim(cols_reg);
    total = nr * nc;
    if (load_pos < CELLS) mat[load_pos] = v;
    if (load_pos + 1 < total) begin
      load_pos++;
    end else begin
      load_pos = 0;
      rk = rref_pivots(nr, nc);
      if (has_exp) begin
        e.value = exp_val; e.last = 1'b1; e.rank = exp_rank;
        expected_elems.insert(expected_elems.size(), e);
      end else begin
        for (int i = 0; i < total; i++) begin
          e.value = mat[i];
          e.last = (i + 1 == total);
          e.rank = rk[RANK_W-1:0];
          expected_elems.insert(expected_elems.size(), e);
        end
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one element transfer, with an optional idle gap in front
  task automatic send_element(logic signed [DATA_W-1:0] v, bit has_exp = 1'b0,
                              logic signed [DATA_W-1:0] exp_val = '0,
                              logic [RANK_W-1:0] exp_rank = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    element_value = v;
    do @(posedge clk); while (in_stall);
    absorb_element(v, has_exp, exp_val, exp_rank);
  endtask

  // drop valid and wait until every expected element has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_elems.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROW_COUNT) rows_reg = val;
    else cols_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver stall pattern: bursts, a forced hold-off, or none
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall = 1'b1;
      hold_off--;
    end else if (quiet) begin
      out_stall = 1'b0;
    end else begin
      if (stall_left == 0) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
          stall_on = 1'b0; stall_left = $urandom_range(1, 8);
        end else if (r < 95) begin
          stall_on = 1'b1; stall_left = $urandom_range(1, 3);
        end else begin
          stall_on = 1'b1; stall_left = $urandom_range(10, 40);
        end
      end
      out_stall = stall_on;
      stall_left--;
    end
  end

  // output checker
  always @(posedge clk) begin
    reduced_elem_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_elems.size() == 0) begin
        $display("%0t: unexpected output value=%h last=%b rank=%0d",
                 $time, reduced_value, is_last, rank);
        failed = 1'b1;
      end else begin
        e = expected_elems.pop_front();
        if (reduced_value !== e.value) begin
          $display("%0t: reduced_value expected %h actual %h", $time, e.value,
                   reduced_value);
          failed = 1'b1;
        end
        if (is_last !== e.last) begin
          $display("%0t: is_last expected %b actual %b", $time, e.last, is_last);
          failed = 1'b1;
        end
        if (rank !== e.rank) begin
          $display("%0t: rank expected %0d actual %0d", $time, e.rank, rank);
          failed = 1'b1;
        end
      end
    end
  end

  // directed table
  typedef enum {ROW_CFG, ROW_ELEM} row_kind_t;
  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         val;
    logic signed [DATA_W-1:0] elem;
    bit                       has_exp;
    logic signed [DATA_W-1:0] exp_val;
    logic [RANK_W-1:0]        exp_rank;
  } dir_row_t;

  localparam int DIR_N = 35;
  dir_row_t dir_tbl[DIR_N] = '{
    // 1x1: zero, unit, extremes, tiny
    '{ROW_CFG,  REG_ROW_COUNT, 4'd1, 32'h0, 0, 32'h0, 0},
    '{ROW_CFG,  REG_COL_COUNT, 4'd1, 32'h0, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000000, 1, 32'h00000000, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00010000, 1, 32'h00010000, 1},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h80000000, 1, 32'h00010000, 1},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h7fffffff, 1, 32'h00010000, 1},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000001, 1, 32'h00010000, 1},
    // zero sizes act as one
    '{ROW_CFG,  REG_ROW_COUNT, 4'd0, 32'h0, 0, 32'h0, 0},
    '{ROW_CFG,  REG_COL_COUNT, 4'd0, 32'h0, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'hfffffffd, 1, 32'h00010000, 1},
    // 2x2: row swap, zero matrix, skipped column
    '{ROW_CFG,  REG_ROW_COUNT, 4'd2, 32'h0, 0, 32'h0, 0},
    '{ROW_CFG,  REG_COL_COUNT, 4'd2, 32'h0, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00030000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00020000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'hffff8000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00010000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00050000, 0, 32'h0, 0},
    // 1x2: quotient saturation
    '{ROW_CFG,  REG_ROW_COUNT, 4'd1, 32'h0, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00000001, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h7fffffff, 0, 32'h0, 0},
    // 2x3 load shrunk to 2x1 mid-way
    '{ROW_CFG,  REG_ROW_COUNT, 4'd2, 32'h0, 0, 32'h0, 0},
    '{ROW_CFG,  REG_COL_COUNT, 4'd3, 32'h0, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00020000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h80000000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h00007000, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'hfffe0000, 0, 32'h0, 0},
    '{ROW_CFG,  REG_COL_COUNT, 4'd1, 32'h0, 0, 32'h0, 0},
    '{ROW_ELEM, REG_ROW_COUNT, 4'd0, 32'h12345678, 0, 32'h0, 0}
  };

  function automatic logic [CFG_W-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return CFG_W'($urandom_range(1, 4));
    if (r < 88) return CFG_W'($urandom_range(5, 8));
    if (r < 92) return 4'd0;
    return CFG_W'($urandom_range(9, 15));
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_elem(int style);
    case (style)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000;
      2: return ($urandom_range(0, 2) == 0) ? 32'sh0 : $signed($urandom_range(0, 7)) <<< 16;
      default: return ($urandom_range(0, 1) == 0) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // main stimulus
  initial begin
    int sent, mat_no, total, style, cut;
    for (int i = 0; i < CELLS; i++) mat[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tbl[i].kind == ROW_CFG) write_reg(dir_tbl[i].idx, dir_tbl[i].val);
      else send_element(dir_tbl[i].elem, dir_tbl[i].has_exp, dir_tbl[i].exp_val,
                        dir_tbl[i].exp_rank);
    end

    // random matrices
    sent = 0;
    mat_no = 0;
    while (sent < 450) begin
      if (mat_no % 6 == 0) quiet = ~quiet;
      if (mat_no == 5) begin
        // small matrix, so its output is still held when the next one comes
        write_reg(REG_ROW_COUNT, 4'd2);
        write_reg(REG_COL_COUNT, 4'd2);
      end else if (mat_no == 0 || (mat_no != 6 && $urandom_range(0, 1) == 0)) begin
        write_reg(REG_ROW_COUNT, (mat_no == 3) ? 4'd8 : rand_dim());
        write_reg(REG_COL_COUNT, (mat_no == 3) ? 4'd15 : rand_dim());
      end
      // long receiver hold-off while the next matrix keeps coming
      if (mat_no == 5) hold_off = 3000;
      total = eff_dim(rows_reg) * eff_dim(cols_reg);
      style = $urandom_range(0, 9);
      style = (style < 3) ? 0 : (style < 6) ? 1 : (style < 9) ? 2 : 3;
      // occasionally break a load with a size change
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
      for (int i = 0; i < cut; i++) begin
        send_element(rand_elem(style));
        sent++;
      end
      if (cut < total) begin
        write_reg(REG_COL_COUNT, rand_dim());
        while (load_pos != 0) begin
          send_element(rand_elem(style));
          sent++;
        end
      end
      mat_no++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (!failed) $display("gauss_jordan_rref test passed");
    else $display("gauss_jordan_rref test failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("gauss_jordan_rref test failed");
    $finish;
  end

endmodule

FILE: gauss_jordan_rref.f
rtl/core/gjr_pkg.sv
rtl/core/gjr_div.sv
rtl/core/gjr_datapath.sv
rtl/core/gjr_ctrl.sv
rtl/core/gauss_jordan_rref.sv
sim/tb.sv
